### src/efhps_pkg.sv
// efhps_pkg: shared types, constants and tables for the ecmp flow hash path select block
// no dependencies; imported by every module of the block
`default_nettype none

package efhps_pkg;

  localparam int HASH_W = 32;

  // initial a and b words of the flow hash
  localparam logic [HASH_W-1:0] GOLDEN_WORD = 32'h9e3779b9;
  // low hash bits used for the threshold walk
  localparam int unsigned LOW_MASK = 32'h0000ffff;
  localparam int REM_W = 16;
  localparam int THR_W = REM_W + 1;

  localparam int MAX_PATHS_DEF = 16;

  // one cell of the mix chain per line of the jenkins mix
  localparam int MIX_STEPS = 9;
  localparam int MIX_SHIFT [MIX_STEPS] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};
  localparam bit MIX_LEFT  [MIX_STEPS] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  // ipv6: destination word added to b in each round
  localparam int V6_ROUNDS = 4;
  localparam logic [1:0] V6_B_WORD [V6_ROUNDS] = '{2'd2, 2'd3, 2'd1, 2'd0};

  // address family codes
  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IPV4_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IPV6_EN   = 2'd2;
  localparam logic [HASH_W-1:0]    SEED_RESET    = 32'd1;

  // hash triple carried along the mix chain; x is the word the next cell updates
  typedef struct packed {
    logic [HASH_W-1:0] x;
    logic [HASH_W-1:0] y;
    logic [HASH_W-1:0] z;
  } mix_tri_t;

  // request into the path selector
  typedef struct packed {
    logic             start;
    logic             enable;
    logic [REM_W-1:0] rem;
  } sel_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_SEL,
    ST_LOAD
  } state_t;

endpackage

`default_nettype wire

### src/efhps_mix_cell.sv
// efhps_mix_cell: one line of the jenkins mix, registered, rotating the triple
// depends on efhps_pkg
`default_nettype none

module efhps_mix_cell
  import efhps_pkg::*;
#(
  parameter int SHIFT_AMT  = 13,
  parameter bit SHIFT_LEFT = 1'b0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     vld_i,
  input  wire mix_tri_t tri_i,
  output logic          vld_o,
  output mix_tri_t      tri_o
);

  logic [HASH_W-1:0] diff;
  logic [HASH_W-1:0] shf;
  mix_tri_t          tri_nxt;

  always_comb begin
    diff = tri_i.x - tri_i.y - tri_i.z;
    shf  = SHIFT_LEFT ? (tri_i.z << SHIFT_AMT) : (tri_i.z >> SHIFT_AMT);
    // updated word goes to the back, the next target to the front
    tri_nxt.x = tri_i.y;
    tri_nxt.y = tri_i.z;
    tri_nxt.z = diff ^ shf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tri_o <= tri_nxt;
  end

endmodule

`default_nettype wire

### src/efhps_path_sel.sv
// efhps_path_sel: hash-threshold path walk, one threshold step per cycle
// depends on efhps_pkg
`default_nettype none

module efhps_path_sel
  import efhps_pkg::*;
#(
  parameter int MAX_PATHS = MAX_PATHS_DEF,
  localparam int PathW = $clog2(MAX_PATHS + 1),
  localparam int IdxW  = $clog2(MAX_PATHS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sel_req_t         req,
  input  wire logic [PathW-1:0] paths_i,
  output logic                  done_o,
  output logic      [IdxW-1:0]  idx_o
);

  logic [THR_W-1:0] thr_tab [MAX_PATHS+1];

  // threshold = 1 + 0xffff / paths, worked out at elaboration
  for (genvar P = 0; P <= MAX_PATHS; P++) begin : g_thr
    if (P == 0) begin : g_zero
      assign thr_tab[P] = '0;
    end else begin : g_div
      localparam int unsigned ThrV = 1 + LOW_MASK / P;
      assign thr_tab[P] = THR_W'(ThrV);
    end
  end

  logic             busy_r;
  logic             done_r;
  logic             en_r;
  logic [REM_W-1:0] rem_r;
  logic [THR_W-1:0] thr_r;
  logic [IdxW-1:0]  idx_r;
  logic [PathW-1:0] paths_r;
  logic             step;

  assign step = en_r && (THR_W'(rem_r) > thr_r) &&
                ((PathW'(idx_r) + PathW'(1)) < paths_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && !step) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      en_r    <= req.enable;
      rem_r   <= req.rem;
      thr_r   <= thr_tab[paths_i];
      paths_r <= paths_i;
      idx_r   <= '0;
    end else if (busy_r && step) begin
      rem_r <= rem_r - REM_W'(thr_r);
      idx_r <= idx_r + IdxW'(1);
    end
  end

  assign done_o = done_r;
  assign idx_o  = idx_r;

endmodule

`default_nettype wire

### src/ecmp_flow_hash_path_select.sv
// ecmp_flow_hash_path_select: top level, flow hash over a chain of mix cells and path choice
// depends on efhps_pkg, efhps_mix_cell and efhps_path_sel
`default_nettype none

// Equal-cost multipath next-hop choice. One item at a time: the block takes an
// item when in_tready is high, runs the jenkins mix over its address words through
// a chain of nine registered cells (one mix line per cell, the triple moving one
// cell per cycle), and then walks the low 16 hash bits down by the path threshold
// one step per cycle. An ipv4 item makes one pass of the chain, an ipv6 item four
// passes (the words for the next round are added as the triple re-enters the first
// cell), any other family none. After the passes come s threshold steps (s is the
// chosen path index when the hash decides, else 0); the next item is accepted only
// once the result has been loaded into the output register, which waits for that
// register to be free. The result is held in an output register, so the next item
// can be taken while the previous result waits on out_tready. Configuration writes
// are taken at any cycle and should only be made while no item is in flight.
module ecmp_flow_hash_path_select
  import efhps_pkg::*;
#(
  parameter int MAX_PATHS = MAX_PATHS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input items
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // dst_word0, dst_word1, dst_word2, dst_word3, src_word0, src_word1, src_word2,
  // src_word3, path_count, zero fill
  input  wire logic [263:0]         in_tdata,
  // family, source_present
  input  wire logic [2:0]           in_tuser,
  // result items
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // path_index, flow_hash, zero fill
  output logic      [39:0]          out_tdata,
  // hashed_choice
  output logic                      out_tuser,
  // configuration writes
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [HASH_W-1:0]    cfg_wr_data
);

  localparam int PathW = $clog2(MAX_PATHS + 1);
  localparam int IdxW  = $clog2(MAX_PATHS);

  // configuration registers
  logic [HASH_W-1:0] seed_r;
  logic              v4_en_r;
  logic              v6_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= SEED_RESET;
      v4_en_r <= 1'b0;
      v6_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HASH_SEED: seed_r  <= cfg_wr_data;
        CFG_IPV4_EN:   v4_en_r <= cfg_wr_data[0];
        CFG_IPV6_EN:   v6_en_r <= cfg_wr_data[0];
        default: ;  // index beyond the register list is ignored
      endcase
    end
  end

  // input field unpacking
  logic [1:0]        in_fam;
  logic              in_srcp;
  logic [HASH_W-1:0] in_dst [4];
  logic [HASH_W-1:0] in_src [4];
  logic [4:0]        in_pcnt;
  logic [PathW-1:0]  in_paths;
  logic              in_en;
  logic              in_mixed;

  always_comb begin
    in_fam  = in_tuser[1:0];
    in_srcp = in_tuser[2];
    for (int i = 0; i < 4; i++) begin
      in_dst[i] = in_tdata[i*HASH_W +: HASH_W];
      // missing source words count as zero
      in_src[i] = in_srcp ? in_tdata[(i+4)*HASH_W +: HASH_W] : '0;
    end
    in_pcnt = in_tdata[260:256];
    // zero paths counts as one, more than the maximum saturates
    if (in_pcnt == 5'd0) begin
      in_paths = PathW'(1);
    end else if (int'(in_pcnt) > MAX_PATHS) begin
      in_paths = PathW'(MAX_PATHS);
    end else begin
      in_paths = PathW'(in_pcnt);
    end
    in_en = ((in_fam == FAM_IPV4) && v4_en_r) || ((in_fam == FAM_IPV6) && v6_en_r);
    in_en = in_en && (in_paths >= PathW'(2));
    in_mixed = (in_fam == FAM_IPV4) || (in_fam == FAM_IPV6);
  end

  // state and per-item registers
  state_t            state_r;
  state_t            state_nxt;
  logic [1:0]        fam_r;
  logic [1:0]        round_r;
  logic [HASH_W-1:0] dst_r [4];
  logic [HASH_W-1:0] src_r [4];
  logic [PathW-1:0]  paths_r;
  logic              en_r;
  logic [HASH_W-1:0] hash_r;

  logic              in_acc;
  logic              last_round;
  logic              out_free;
  logic              load_out;

  // mix chain
  logic              chain_vld [MIX_STEPS+1];
  mix_tri_t          chain_tri [MIX_STEPS+1];
  logic [MIX_STEPS-1:0] cell_vld;
  logic              chain_done;
  mix_tri_t          chain_out;
  // triple entering the first cell
  logic              inj_vld;
  mix_tri_t          inj_tri;

  assign chain_vld[0] = inj_vld;
  assign chain_tri[0] = inj_tri;

  for (genvar k = 0; k < MIX_STEPS; k++) begin : g_cell
    efhps_mix_cell #(
      .SHIFT_AMT  (MIX_SHIFT[k]),
      .SHIFT_LEFT (MIX_LEFT[k])
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (chain_vld[k]),
      .tri_i (chain_tri[k]),
      .vld_o (chain_vld[k+1]),
      .tri_o (chain_tri[k+1])
    );
    assign cell_vld[k] = chain_vld[k+1];
  end

  assign chain_done = chain_vld[MIX_STEPS];
  assign chain_out  = chain_tri[MIX_STEPS];

  // a pass ends with the triple back in a, b, c order
  assign last_round = (fam_r == FAM_IPV4) || (round_r == 2'(V6_ROUNDS - 1));
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid || out_tready;

  // words entering the first cell: initial words at acceptance, next round after a pass
  mix_tri_t          inj_base;
  logic [HASH_W-1:0] add_a;
  logic [HASH_W-1:0] add_b;
  logic [HASH_W-1:0] add_c;
  logic [1:0]        round_nxt;

  always_comb begin
    round_nxt = round_r + 2'd1;
    if (state_r == ST_IDLE) begin
      inj_base.x = GOLDEN_WORD;
      inj_base.y = GOLDEN_WORD;
      inj_base.z = seed_r;
      add_a      = in_dst[0];
      add_b      = (in_fam == FAM_IPV6) ? in_dst[2] : in_src[0];
      add_c      = (in_fam == FAM_IPV6) ? in_src[0] : '0;
    end else begin
      inj_base   = chain_out;
      add_a      = dst_r[round_nxt];
      add_b      = dst_r[V6_B_WORD[round_nxt]];
      add_c      = src_r[round_nxt];
    end
    inj_tri.x = inj_base.x + add_a;
    inj_tri.y = inj_base.y + add_b;
    inj_tri.z = inj_base.z + add_c;
  end

  // path selector
  sel_req_t          sel_req;
  logic [PathW-1:0]  sel_paths;
  logic              sel_done;
  logic [IdxW-1:0]   sel_idx;

  efhps_path_sel #(
    .MAX_PATHS (MAX_PATHS)
  ) u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sel_req),
    .paths_i (sel_paths),
    .done_o  (sel_done),
    .idx_o   (sel_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_mixed ? ST_MIX : ST_SEL;
        end
      end
      ST_MIX: begin
        if (chain_done && last_round) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        if (sel_done) begin
          state_nxt = out_free ? ST_IDLE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready      = 1'b0;
    inj_vld        = 1'b0;
    sel_req.start  = 1'b0;
    sel_req.enable = en_r;
    sel_req.rem    = chain_out.z[REM_W-1:0];
    sel_paths      = paths_r;
    load_out       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        inj_vld   = in_tvalid && in_mixed;
        // other families skip the mix: hash is the seed, default path
        sel_req.start  = in_tvalid && !in_mixed;
        sel_req.enable = 1'b0;
        sel_req.rem    = seed_r[REM_W-1:0];
        sel_paths      = in_paths;
      end
      ST_MIX: begin
        inj_vld       = chain_done && !last_round;
        sel_req.start = chain_done && last_round;
      end
      ST_SEL: begin
        load_out = sel_done && out_free;
      end
      ST_LOAD: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item payload, captured at acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fam_r   <= in_fam;
      paths_r <= in_paths;
      en_r    <= in_en;
      for (int i = 0; i < 4; i++) begin
        dst_r[i] <= in_dst[i];
        src_r[i] <= in_src[i];
      end
    end
  end

  // round count of the ipv6 passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r <= 2'd0;
    end else if (in_acc) begin
      round_r <= 2'd0;
    end else if ((state_r == ST_MIX) && chain_vld[0]) begin
      round_r <= round_nxt;
    end
  end

  // final hash word, kept while the path walk runs
  always_ff @(posedge clk) begin
    if (sel_req.start) begin
      hash_r <= (state_r == ST_IDLE) ? seed_r : chain_out.z;
    end
  end

  // output register
  logic              out_vld_r;
  logic [3:0]        out_idx_r;
  logic [HASH_W-1:0] out_hash_r;
  logic              out_hashed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r    <= 4'(sel_idx);
      out_hash_r   <= hash_r;
      out_hashed_r <= en_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_hash_r, out_idx_r};
  assign out_tuser  = out_hashed_r;

  // no triple may be in the chain while a new item can be taken
  a_chain_empty_when_ready : assert property (
    @(posedge clk) disable iff (!rst_n) in_tready |-> (cell_vld == '0)
  ) else $error("mix chain busy while accepting");

  // end of a pass only while mixing
  a_chain_done_in_mix : assert property (
    @(posedge clk) disable iff (!rst_n) chain_done |-> (state_r == ST_MIX)
  ) else $error("mix chain output outside the mix phase");

  // at most one triple travels the chain
  a_single_triple : assert property (
    @(posedge clk) disable iff (!rst_n) $onehot0(cell_vld)
  ) else $error("more than one triple in the mix chain");

  // the walk finishes only while the top waits for it
  a_sel_done_in_sel : assert property (
    @(posedge clk) disable iff (!rst_n) sel_done |-> (state_r == ST_SEL)
  ) else $error("path walk finished outside the select phase");

  // a result is loaded only from the select or load phase
  a_load_phase : assert property (
    @(posedge clk) disable iff (!rst_n)
      load_out |-> ((state_r == ST_SEL) || (state_r == ST_LOAD))
  ) else $error("result loaded in the wrong phase");

endmodule

`default_nettype wire

### tb/tb_ecmp_flow_hash_path_select.sv
// tb_ecmp_flow_hash_path_select: self-checking bench for the ecmp flow hash path select block
// depends on efhps_pkg and ecmp_flow_hash_path_select; a directed script, then random phases
// checked against a jenkins mix and hash-threshold predictor
module tb_ecmp_flow_hash_path_select;
  import efhps_pkg::*;

  // families with no mix, not named in the package
  localparam logic [1:0] FAM_OTHER    = 2'd2;
  localparam logic [1:0] FAM_RESERVED = 2'd3;
  // register index past the end of the list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int          CLK_HALF      = 5;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // settle margin after the last result, so that it covers any item in flight
  localparam int          SETTLE_CYCLES = 64;
  localparam int          PHASES        = 8;
  localparam int          PHASE_ITEMS   = 240;
  localparam int          HOLD_OFF_LEN  = 400;
  localparam int          REPORT_MAX    = 40;
  // per-phase enables, bit p for phase p
  localparam logic [PHASES-1:0] V4_PLAN = 8'b1001_1111;
  localparam logic [PHASES-1:0] V6_PLAN = 8'b1011_1011;

  typedef struct packed {
    logic [1:0]       family;
    logic             src_present;
    logic [3:0][31:0] dst;
    logic [3:0][31:0] src;
    logic [4:0]       path_count;
  } flow_item_t;

  typedef struct packed {
    logic [3:0]  path_index;
    logic [31:0] flow_hash;
    logic        hashed_choice;
  } path_result_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_words_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [31:0]          reg_value;
    flow_item_t           item;
    logic                 typed;
    path_result_t         typed_result;
  } script_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [263:0]         in_tdata;
  logic [2:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [39:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HASH_W-1:0]    cfg_wr_data;

  // bench copy of the configuration registers
  logic [31:0] seed_reg;
  logic        v4_enable;
  logic        v6_enable;

  path_result_t expected_choices[$];
  script_row_t  directed_rows[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_request;

  ecmp_flow_hash_path_select DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // one 96-bit jenkins mix, line for line
  function automatic mix_words_t jenkins_mix(input mix_words_t m);
    logic [31:0] a, b, c;
    a = m.a;
    b = m.b;
    c = m.c;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    return '{a: a, b: b, c: c};
  endfunction

  // flow hash and hash-threshold path choice under the current register copy
  function automatic path_result_t predict_choice(input flow_item_t it);
    mix_words_t       m;
    logic [3:0][31:0] s;
    int unsigned      paths, thr, rem, idx;
    logic             en;
    s = it.src_present ? it.src : '0;
    paths = 32'(it.path_count);
    if (paths == 0) paths = 1;
    if (paths > MAX_PATHS_DEF) paths = MAX_PATHS_DEF;
    m.a = GOLDEN_WORD;
    m.b = GOLDEN_WORD;
    m.c = seed_reg;
    if (it.family == FAM_IPV4) begin
      m.a += it.dst[0];
      m.b += s[0];
      m = jenkins_mix(m);
    end else if (it.family == FAM_IPV6) begin
      // destination words go to b in a permuted order, one source word per round
      m.a += it.dst[0]; m.b += it.dst[2]; m.c += s[0]; m = jenkins_mix(m);
      m.a += it.dst[1]; m.b += it.dst[3]; m.c += s[1]; m = jenkins_mix(m);
      m.a += it.dst[2]; m.b += it.dst[1]; m.c += s[2]; m = jenkins_mix(m);
      m.a += it.dst[3]; m.b += it.dst[0]; m.c += s[3]; m = jenkins_mix(m);
    end
    en = ((it.family == FAM_IPV4 && v4_enable) || (it.family == FAM_IPV6 && v6_enable))
         && paths >= 2;
    idx = 0;
    if (en) begin
      rem = 32'(m.c[15:0]);
      thr = 1 + 32'hffff / paths;
      while (rem > thr && idx + 1 < paths) begin
        idx++;
        rem -= thr;
      end
    end
    return '{path_index: idx[3:0], flow_hash: m.c, hashed_choice: en};
  endfunction

  function automatic script_row_t item_row(input logic [1:0] fam, input logic srcp,
                                           input logic [31:0] dpat, input logic [31:0] spat,
                                           input logic [4:0] paths, input logic typed,
                                           input logic [3:0] w_idx, input logic [31:0] w_hash,
                                           input logic w_hashed);
    script_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.family = fam;
    r.item.src_present = srcp;
    r.item.dst = {4{dpat}};
    r.item.src = {4{spat}};
    r.item.path_count = paths;
    r.typed = typed;
    r.typed_result = '{path_index: w_idx, flow_hash: w_hash, hashed_choice: w_hashed};
    return r;
  endfunction

  function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  // mostly random words, now and then all zeros or all ones
  function automatic logic [31:0] address_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 32'h0;
    if (pick == 1) return 32'hffff_ffff;
    return $urandom();
  endfunction

  function automatic flow_item_t random_item();
    flow_item_t  it;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)       it.family = FAM_IPV4;
    else if (pick < 8)  it.family = FAM_IPV6;
    else if (pick == 8) it.family = FAM_OTHER;
    else                it.family = FAM_RESERVED;
    it.src_present = 1'($urandom_range(0, 1));
    for (int i = 0; i < 4; i++) begin
      it.dst[i] = address_word();
      it.src[i] = address_word();
    end
    // mostly real multipath counts, with the zero, single and oversized corners mixed in
    pick = $urandom_range(0, 19);
    if (pick == 0)      it.path_count = 5'd0;
    else if (pick == 1) it.path_count = 5'($urandom_range(17, 31));
    else if (pick == 2) it.path_count = 5'd1;
    else                it.path_count = 5'($urandom_range(2, 16));
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch on %s at cycle %0d: got 0x%08h, expected 0x%08h",
               what, cycle_count, got, want);
  endtask

  // called at a falling edge while the block is idle; bench copy follows at once
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wr_data = val;
    case (idx)
      CFG_HASH_SEED: seed_reg = val;
      CFG_IPV4_EN:   v4_enable = val[0];
      CFG_IPV6_EN:   v6_enable = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // drop valid, wait for every outstanding result, then let the pipe empty
  task automatic settle_idle();
    in_tvalid = 1'b0;
    while (expected_choices.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // entered and left at a falling edge; valid stays up between back-to-back items
  task automatic offer_item(input flow_item_t it, input logic typed,
                            input path_result_t typed_result);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata = {3'b000, it.path_count, it.src, it.dst};
    in_tuser = {it.src_present, it.family};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    // registers are steady while items run, so the prediction can be made at acceptance
    expected_choices.push_back(typed ? typed_result : predict_choice(it));
    @(negedge clk);
  endtask

  // receiver: random stalls, or a long hold-off counted down here when one is requested
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_off_request != 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // compare each accepted result with the oldest outstanding prediction
  always @(posedge clk) begin : result_check
    path_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_choices.size() == 0) begin
        report_mismatch("result with no item outstanding", out_tdata[35:4], 32'h0);
      end else begin
        want = expected_choices.pop_front();
        if (out_tdata[3:0] !== want.path_index)
          report_mismatch("path_index", 32'(out_tdata[3:0]), 32'(want.path_index));
        if (out_tdata[35:4] !== want.flow_hash)
          report_mismatch("flow_hash", out_tdata[35:4], want.flow_hash);
        if (out_tuser !== want.hashed_choice)
          report_mismatch("hashed_choice", 32'(out_tuser), 32'(want.hashed_choice));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] seed_pick;
    cycle_count = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_request = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wr_data = '0;
    // register values after reset
    seed_reg = SEED_RESET;
    v4_enable = 1'b0;
    v6_enable = 1'b0;

    // directed script; hashes are typed in only where no mix runs
    // reset state: other families return the seed, multipath off everywhere
    directed_rows.push_back(item_row(FAM_OTHER, 1'b1, '1, '1, 5'd16, 1'b1, 4'd0, 32'd1, 1'b0));
    directed_rows.push_back(item_row(FAM_RESERVED, 1'b0, '0, '0, 5'd0, 1'b1, 4'd0, 32'd1, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV4, 1'b1, '1, '1, 5'd16, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV6, 1'b1, '1, '1, 5'd31, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(cfg_row(CFG_IPV4_EN, 32'd1));
    directed_rows.push_back(cfg_row(CFG_IPV6_EN, 32'd1));
    // hashed choice: field extremes, single path, zero count, oversized counts
    directed_rows.push_back(item_row(FAM_IPV4, 1'b0, '0, '0, 5'd16, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV4, 1'b1, '1, '1, 5'd2, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV4, 1'b0, 32'h0a00_0001, '1, 5'd1,
                                     1'b0, '0, '0, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV6, 1'b1, '1, '1, 5'd16, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV6, 1'b0, 32'h2001_0db8, '1, 5'd0,
                                     1'b0, '0, '0, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV6, 1'b1, 32'hfe80_0000, 32'h0000_0001, 5'd17,
                                     1'b0, '0, '0, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV4, 1'b1, 32'hc0a8_0001, 32'hc0a8_0002, 5'd31,
                                     1'b0, '0, '0, 1'b0));
    // a zero seed is taken as it is
    directed_rows.push_back(cfg_row(CFG_HASH_SEED, 32'h0));
    directed_rows.push_back(item_row(FAM_OTHER, 1'b1, '1, '1, 5'd16, 1'b1, 4'd0, 32'h0, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV4, 1'b0, '0, '0, 5'd16, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(cfg_row(CFG_HASH_SEED, 32'hffff_ffff));
    directed_rows.push_back(item_row(FAM_RESERVED, 1'b0, '0, '0, 5'd5,
                                     1'b1, 4'd0, 32'hffff_ffff, 1'b0));
    directed_rows.push_back(item_row(FAM_IPV6, 1'b0, '0, '0, 5'd3, 1'b0, '0, '0, 1'b0));
    // a write past the register list must leave the seed alone
    directed_rows.push_back(cfg_row(CFG_SPARE, 32'h1234_5678));
    directed_rows.push_back(item_row(FAM_OTHER, 1'b1, '1, '1, 5'd16,
                                     1'b1, 4'd0, 32'hffff_ffff, 1'b0));
    // ipv4 switched back off while ipv6 stays on
    directed_rows.push_back(cfg_row(CFG_IPV4_EN, 32'd0));
    directed_rows.push_back(item_row(FAM_IPV4, 1'b1, '1, '1, 5'd16, 1'b0, '0, '0, 1'b0));

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_idle();
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        offer_item(directed_rows[i].item, directed_rows[i].typed,
                   directed_rows[i].typed_result);
      end
    end

    // random phases: each sets all three registers, then runs its idle pattern
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      if (p == 0) begin
        seed_pick = SEED_RESET;
      end else if (p == 1) begin
        seed_pick = 32'hffff_ffff;
      end else begin
        seed_pick = $urandom();
        if (seed_pick == 0) seed_pick = 32'd1;
      end
      write_register(CFG_HASH_SEED, seed_pick);
      write_register(CFG_IPV4_EN, {31'd0, V4_PLAN[p]});
      write_register(CFG_IPV6_EN, {31'd0, V6_PLAN[p]});
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // long receiver hold-off while items keep coming, so the output register
      // fills and in_tready has to drop
      if (p == 4) hold_off_request = HOLD_OFF_LEN;
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer_item(random_item(), 1'b0, '0);
    end

    settle_idle();
    if (mismatch_count == 0 && expected_choices.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
src/efhps_pkg.sv
src/efhps_mix_cell.sv
src/efhps_path_sel.sv
src/ecmp_flow_hash_path_select.sv
tb/tb_ecmp_flow_hash_path_select.sv
